@@ rtl/tvg_pkg.sv @@
package tvg_pkg;

    localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_SMOOTHING_FLOOR = 2'd2;

    localparam int PIX_W      = 16;
    localparam int VAL_W      = 18;
    localparam int DIV_STEPS  = 31;
    localparam int ROOT_STEPS = 16;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_RD_ABOVE,
        SEQ_RD_RIGHT,
        SEQ_NX,
        SEQ_NY,
        SEQ_EMIT1,
        SEQ_NX2,
        SEQ_EMIT2,
        SEQ_EMIT3,
        SEQ_FINISH
    } tvg_seq_state_t;

    typedef enum logic [2:0] {
        NRM_IDLE,
        NRM_SQUARE,
        NRM_SETUP,
        NRM_DIVIDE,
        NRM_ROOT,
        NRM_DONE
    } tvg_nrm_state_t;

    typedef struct packed {
        logic              done;
        logic signed [15:0] value;
    } tvg_nrm_rsp_t;

endpackage

@@ rtl/tvg_norm.sv @@
module tvg_norm
    import tvg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [16:0] d,
    input  logic signed [16:0] e,
    input  logic [15:0]        mu,
    output tvg_nrm_rsp_t       rsp
);

    tvg_nrm_state_t state_reg, state_next;

    logic [15:0] ua_reg, ub_reg, mu_reg;
    logic        neg_reg;
    logic [31:0] ua2_reg, ub2_reg, m2_reg;
    logic        big_reg;
    logic [33:0] rem_reg, div_reg;
    logic [30:0] low_reg, quot_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] op_reg, res_reg, one_reg;
    logic [14:0] mag_reg;

    logic [16:0] abs_d, abs_e;
    logic [32:0] sum_s;
    logic        big;
    logic [61:0] dividend;
    logic [34:0] shifted;
    logic        ge;
    logic [30:0] quot_next;
    logic [31:0] root_sum, res_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= NRM_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        abs_d = d[16] ? 17'(-d) : 17'(d);
        abs_e = e[16] ? 17'(-e) : 17'(e);
        sum_s = {1'b0, ua2_reg} + {1'b0, ub2_reg};
        big = sum_s >= {1'b0, m2_reg};
        dividend = big ? {ua2_reg, 30'b0} : (62'({ua_reg, 15'b0}) + 62'(mu_reg));
        shifted = {rem_reg, low_reg[30]};
        ge = shifted >= {1'b0, div_reg};
        quot_next = {quot_reg[29:0], ge};
        root_sum = res_reg + one_reg;
        res_next = (op_reg >= root_sum) ? ((res_reg >> 1) + one_reg) : (res_reg >> 1);
        case (state_reg)
            NRM_IDLE: begin
                if (start) begin
                    state_next = NRM_SQUARE;
                end
            end
            NRM_SQUARE: state_next = NRM_SETUP;
            NRM_SETUP:  state_next = NRM_DIVIDE;
            NRM_DIVIDE: begin
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    state_next = big_reg ? NRM_ROOT : NRM_DONE;
                end
            end
            NRM_ROOT: begin
                if (cnt_reg == 5'(ROOT_STEPS - 1)) begin
                    state_next = NRM_DONE;
                end
            end
            NRM_DONE: state_next = start ? NRM_SQUARE : NRM_IDLE;
            default: state_next = NRM_IDLE;
        endcase
        rsp.done = (state_reg == NRM_DONE);
        rsp.value = neg_reg ? -$signed({1'b0, mag_reg}) : $signed({1'b0, mag_reg});
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == NRM_IDLE || state_reg == NRM_DONE) && start) begin
            ua_reg  <= abs_d[15:0];
            ub_reg  <= abs_e[15:0];
            neg_reg <= d[16];
            mu_reg  <= (mu == 16'd0) ? 16'd1 : mu;
        end
        case (state_reg)
            NRM_SQUARE: begin
                ua2_reg <= ua_reg * ua_reg;
                ub2_reg <= ub_reg * ub_reg;
                m2_reg  <= mu_reg * mu_reg;
            end
            NRM_SETUP: begin
                big_reg  <= big;
                rem_reg  <= 34'(dividend[61:31]);
                low_reg  <= dividend[30:0];
                div_reg  <= big ? 34'(sum_s) : 34'({mu_reg, 1'b0});
                quot_reg <= '0;
                cnt_reg  <= '0;
            end
            NRM_DIVIDE: begin
                rem_reg  <= ge ? 34'(shifted - {1'b0, div_reg}) : 34'(shifted);
                low_reg  <= {low_reg[29:0], 1'b0};
                quot_reg <= quot_next;
                cnt_reg  <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1)) begin
                    op_reg  <= {1'b0, quot_next};
                    res_reg <= '0;
                    one_reg <= 32'h4000_0000;
                    mag_reg <= quot_next[14:0];
                    cnt_reg <= '0;
                end
            end
            NRM_ROOT: begin
                if (op_reg >= root_sum) begin
                    op_reg <= op_reg - root_sum;
                end
                res_reg <= res_next;
                one_reg <= one_reg >> 2;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(ROOT_STEPS - 1)) begin
                    mag_reg <= 15'((res_next + 32'd1) >> 1);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

@@ rtl/tvg_line_store.sv @@
module tvg_line_store
    import tvg_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic             aclk,
    input  logic             pix_rd_en,
    input  logic [AW-1:0]    pix_rd_addr,
    output logic [PIX_W-1:0] pix_rd_data,
    input  logic             pix_we,
    input  logic [AW-1:0]    pix_wr_addr,
    input  logic [PIX_W-1:0] pix_wr_data,
    input  logic             vert_rd_en,
    input  logic [AW-1:0]    vert_rd_addr,
    output logic [15:0]      vert_rd_data,
    input  logic             vert_we,
    input  logic [AW-1:0]    vert_wr_addr,
    input  logic [15:0]      vert_wr_data
);

    logic [PIX_W-1:0] pix_mem [DEPTH];
    logic [15:0]      vert_mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (pix_we) begin
            pix_mem[pix_wr_addr] <= pix_wr_data;
        end
        if (pix_rd_en) begin
            pix_rd_data <= pix_mem[pix_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (vert_we) begin
            vert_mem[vert_wr_addr] <= vert_wr_data;
        end
        if (vert_rd_en) begin
            vert_rd_data <= vert_mem[vert_rd_addr];
        end
    end

endmodule

@@ rtl/smoothed_tv_gradient_stream_unit.sv @@
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata: pixel
// m_        out  m_tvalid/m_tready    m_tdata: value, out_row, out_column; tlast; tuser
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// row-0 pixels skip to finish; others normalize twice, and in the last row from column 1 thrice
// each component uses one shared unit: 31-step divider, 16-step root if ua^2+ub^2 >= mu^2
// reset clears counters and loads config defaults; the line stores need no clearing pass
// a stalled m_ side holds the sequencer at its next result; s_tready waits for the sequencer

module smoothed_tv_gradient_stream_unit
    import tvg_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // pixel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,    // value, out_row, out_column
    output logic        m_tlast,
    output logic        m_tuser,    // end_of_frame
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WW    = COL_W + 1;
    localparam int HW    = ROW_W + 1;

    tvg_seq_state_t state_reg, state_next;

    logic [10:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [15:0] floor_reg;

    logic [COL_W-1:0] col_cnt_reg, col_reg;
    logic [ROW_W-1:0] row_cnt_reg, row_reg;
    logic signed [15:0] pix_reg, prev_reg, above_reg;
    logic signed [16:0] ux_reg, uy_reg;
    logic signed [15:0] nx_reg, ny_reg, nx2_reg, left_reg, lastleft_reg;

    logic [VAL_W-1:0] out_val_reg;
    logic [11:0]      out_row_reg;
    logic [9:0]       out_col_reg;
    logic             out_last_reg, out_eof_reg, out_valid_reg;

    logic [WW-1:0] w_use;
    logic [HW-1:0] h_use;
    logic [COL_W-1:0] start_c;
    logic [ROW_W-1:0] start_r;
    logic has_right, last_col, last_row, col_ge1, col_ge2, row_ge2;
    logic out_free, cfg_wr, accept;

    logic               nrm_start;
    logic signed [16:0] nrm_d, nrm_e, ux_next, uy_next;
    tvg_nrm_rsp_t       nrm_rsp;

    logic             pix_rd_en, vert_rd_en, vert_we;
    logic [COL_W-1:0] pix_rd_addr, vert_rd_addr;
    logic [PIX_W-1:0] pix_rd_data;
    logic [15:0]      vert_rd_data;

    logic             emit, emit_last, emit_eof;
    logic [VAL_W-1:0] emit_val;
    logic [11:0]      emit_row;
    logic [9:0]       emit_col;
    logic signed [17:0] hp, vp, vert_s;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;
    assign s_tready  = (state_reg == SEQ_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {out_col_reg, out_row_reg, out_val_reg};
    assign m_tlast   = out_last_reg;
    assign m_tuser   = out_eof_reg;

    always_comb begin
        if (image_width_reg < 11'd2) begin
            w_use = WW'(2);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            w_use = WW'(MAX_WIDTH);
        end else begin
            w_use = WW'(image_width_reg);
        end
        if (image_height_reg < 13'd2) begin
            h_use = HW'(2);
        end else if (32'(image_height_reg) > MAX_HEIGHT) begin
            h_use = HW'(MAX_HEIGHT);
        end else begin
            h_use = HW'(image_height_reg);
        end
    end

    always_comb begin
        if ({1'b0, col_cnt_reg} >= w_use || {1'b0, row_cnt_reg} >= h_use) begin
            start_c = '0;
            start_r = '0;
        end else begin
            start_c = col_cnt_reg;
            start_r = row_cnt_reg;
        end
        has_right = ({1'b0, col_reg} + WW'(1)) < w_use;
        last_col  = ({1'b0, col_reg} + WW'(1)) == w_use;
        last_row  = ({1'b0, row_reg} + HW'(1)) == h_use;
        col_ge1   = (col_reg != '0);
        col_ge2   = (32'(col_reg) >= 32'd2);
        row_ge2   = (32'(row_reg) >= 32'd2);
        ux_next   = has_right ? (17'($signed(pix_rd_data)) - 17'(above_reg)) : 17'sd0;
        uy_next   = 17'(pix_reg) - 17'(above_reg);
        vert_s    = 18'($signed(vert_rd_data));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        nrm_start    = 1'b0;
        nrm_d        = ux_next;
        nrm_e        = uy_next;
        pix_rd_en    = 1'b0;
        pix_rd_addr  = start_c;
        vert_rd_en   = 1'b0;
        vert_rd_addr = col_reg;
        vert_we      = 1'b0;
        emit         = 1'b0;
        emit_last    = 1'b0;
        emit_eof     = 1'b0;
        emit_val     = '0;
        emit_row     = 12'(row_reg);
        emit_col     = 10'(col_reg);
        hp           = '0;
        vp           = '0;
        case (state_reg)
            SEQ_IDLE: begin
                if (accept) begin
                    pix_rd_en  = (start_r != '0);
                    state_next = (start_r != '0) ? SEQ_RD_ABOVE : SEQ_FINISH;
                end
            end
            SEQ_RD_ABOVE: begin
                pix_rd_en   = 1'b1;
                pix_rd_addr = COL_W'({1'b0, col_reg} + WW'(1));
                state_next  = SEQ_RD_RIGHT;
            end
            SEQ_RD_RIGHT: begin
                vert_rd_en = 1'b1;
                nrm_start  = 1'b1;
                state_next = SEQ_NX;
            end
            SEQ_NX: begin
                nrm_d = uy_reg;
                nrm_e = ux_reg;
                if (nrm_rsp.done) begin
                    nrm_start  = 1'b1;
                    state_next = SEQ_NY;
                end
            end
            SEQ_NY: begin
                if (nrm_rsp.done) begin
                    state_next = SEQ_EMIT1;
                end
            end
            SEQ_EMIT1: begin
                hp = col_ge1 ? (18'(nx_reg) - 18'(left_reg)) : 18'sd0;
                vp = row_ge2 ? (18'(ny_reg) - vert_s) : 18'sd0;
                emit_val  = VAL_W'(-(hp + vp));
                emit_row  = 12'(row_reg - ROW_W'(1));
                emit_last = !(last_row && col_ge1);
                nrm_d     = 17'(pix_reg) - 17'(prev_reg);
                nrm_e     = 17'sd0;
                if (out_free) begin
                    emit    = 1'b1;
                    vert_we = 1'b1;
                    if (last_row && col_ge1) begin
                        vert_rd_en   = 1'b1;
                        vert_rd_addr = col_reg - COL_W'(1);
                        nrm_start    = 1'b1;
                        state_next   = SEQ_NX2;
                    end else begin
                        state_next = SEQ_FINISH;
                    end
                end
            end
            SEQ_NX2: begin
                if (nrm_rsp.done) begin
                    state_next = SEQ_EMIT2;
                end
            end
            SEQ_EMIT2: begin
                hp = col_ge2 ? (18'(nx2_reg) - 18'(lastleft_reg)) : 18'sd0;
                emit_val  = VAL_W'(vert_s - hp);
                emit_col  = 10'(col_reg - COL_W'(1));
                emit_last = !last_col;
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = last_col ? SEQ_EMIT3 : SEQ_FINISH;
                end
            end
            SEQ_EMIT3: begin
                emit_val  = VAL_W'(18'(lastleft_reg) + 18'(ny_reg));
                emit_last = 1'b1;
                emit_eof  = 1'b1;
                if (out_free) begin
                    emit       = 1'b1;
                    state_next = SEQ_FINISH;
                end
            end
            SEQ_FINISH: state_next = SEQ_IDLE;
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= 11'd1024;
            image_height_reg <= 13'd1024;
            floor_reg        <= 16'd41;
            col_cnt_reg      <= '0;
            row_cnt_reg      <= '0;
            prev_reg         <= '0;
            left_reg         <= '0;
            lastleft_reg     <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_index)
                    REG_IMAGE_WIDTH: begin
                        image_width_reg <= cfg_data[10:0];
                        col_cnt_reg     <= '0;
                        row_cnt_reg     <= '0;
                    end
                    REG_IMAGE_HEIGHT: begin
                        image_height_reg <= cfg_data[12:0];
                        col_cnt_reg      <= '0;
                        row_cnt_reg      <= '0;
                    end
                    REG_SMOOTHING_FLOOR: begin
                        floor_reg   <= cfg_data;
                        col_cnt_reg <= '0;
                        row_cnt_reg <= '0;
                    end
                    default: begin
                    end
                endcase
            end else if (state_reg == SEQ_FINISH) begin
                if (has_right) begin
                    col_cnt_reg <= col_reg + COL_W'(1);
                    row_cnt_reg <= row_reg;
                end else begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= last_row ? '0 : (row_reg + ROW_W'(1));
                end
            end
            if (state_reg == SEQ_FINISH) begin
                prev_reg <= pix_reg;
            end
            if (state_reg == SEQ_EMIT1 && out_free) begin
                left_reg <= nx_reg;
            end
            if (state_reg == SEQ_EMIT2 && out_free) begin
                lastleft_reg <= nx2_reg;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg <= $signed(s_tdata);
            col_reg <= start_c;
            row_reg <= start_r;
        end
        if (state_reg == SEQ_RD_ABOVE) begin
            above_reg <= $signed(pix_rd_data);
        end
        if (state_reg == SEQ_RD_RIGHT) begin
            ux_reg <= ux_next;
            uy_reg <= uy_next;
        end
        if (state_reg == SEQ_NX && nrm_rsp.done) begin
            nx_reg <= nrm_rsp.value;
        end
        if (state_reg == SEQ_NY && nrm_rsp.done) begin
            ny_reg <= nrm_rsp.value;
        end
        if (state_reg == SEQ_NX2 && nrm_rsp.done) begin
            nx2_reg <= nrm_rsp.value;
        end
        if (emit) begin
            out_val_reg  <= emit_val;
            out_row_reg  <= emit_row;
            out_col_reg  <= emit_col;
            out_last_reg <= emit_last;
            out_eof_reg  <= emit_eof;
        end
    end

    tvg_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (nrm_start),
        .d       (nrm_d),
        .e       (nrm_e),
        .mu      (floor_reg),
        .rsp     (nrm_rsp)
    );

    tvg_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_store (
        .aclk         (aclk),
        .pix_rd_en    (pix_rd_en),
        .pix_rd_addr  (pix_rd_addr),
        .pix_rd_data  (pix_rd_data),
        .pix_we       (state_reg == SEQ_FINISH),
        .pix_wr_addr  (col_reg),
        .pix_wr_data  (pix_reg),
        .vert_rd_en   (vert_rd_en),
        .vert_rd_addr (vert_rd_addr),
        .vert_rd_data (vert_rd_data),
        .vert_we      (vert_we),
        .vert_wr_addr (col_reg),
        .vert_wr_data (ny_reg)
    );

    a_single_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second pixel transfer while one is in work");

    a_eof_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end without last of run");

    a_value_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[17:0]) >= -18'sd65536 &&
                      $signed(m_tdata[17:0]) <= 18'sd65536))
        else $error("result value out of range");

endmodule
